>>> src/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg: shared types and constants of the TCP reorder buffer
// Widths, port codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package trb_pkg;

  localparam int unsigned HoldDepth = 16;
  localparam int unsigned TagBits   = 16;
  localparam int unsigned IdxBits   = $clog2(HoldDepth);
  localparam logic [15:0] MssReset  = 16'd1460;
  localparam logic [31:0] SeqReset  = 32'd1;

  localparam logic [1:0] PortNonTcp  = 2'd0;
  localparam logic [1:0] PortAllTcp  = 2'd1;
  localparam logic [1:0] PortOrdered = 2'd2;

  localparam logic [0:0] RegMss = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StClassify,
    StEmit,
    StAdvance,
    StScan,
    StCopy
  } state_e;

  typedef struct packed {
    logic load;       // capture the input beat
    logic hold;       // store the captured packet in the free slot
    logic advance;    // expected += mss and free stale entries
    logic take_hit;   // free the matched entry
    logic sel_held;   // output tag comes from the matched entry
  } cmd_t;

  typedef struct packed {
    logic valid_tcp;
    logic stale_or_dup;
    logic is_expected;
    logic emits;
    logic hit;         // an entry matches expected_seq
    logic hit_emits;
    logic full;
  } sts_t;

endpackage

>>> src/trb_datapath.sv
// ----------------------------------------------------------------------------
// trb_datapath: captured packet, expected number and hold table
// Compares against all held entries and updates them on controller command.
// ----------------------------------------------------------------------------
module trb_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trb_pkg::cmd_t               cmd_i,
  output trb_pkg::sts_t               sts_o,
  input  logic                        in_valid_tcp_i,
  input  logic [31:0]                 in_seq_i,
  input  logic [trb_pkg::TagBits-1:0] in_tag_i,
  input  logic                        in_frag_i,
  input  logic                        in_lastf_i,
  input  logic [trb_pkg::TagBits-1:0] in_orig_i,
  input  logic                        cfg_we_i,
  input  logic [15:0]                 cfg_data_i,
  output logic [15:0]                 mss_o,
  output logic [trb_pkg::TagBits-1:0] item_tag_o,
  output logic [trb_pkg::TagBits-1:0] emit_tag_o
);
  import trb_pkg::*;

  logic                 valid_q;
  logic [31:0]          seq_q;
  logic [TagBits-1:0]   tag_q, etag_q;
  logic                 emits_q;
  logic [31:0]          exp_q, exp_d;
  logic [15:0]          mss_q;
  logic [HoldDepth-1:0] hv_q;
  logic [31:0]          hseq_q [HoldDepth];
  logic [TagBits-1:0]   htag_q [HoldDepth];
  logic [HoldDepth-1:0] hemit_q;
  logic [HoldDepth-1:0] dup_v, hit_v;
  logic [IdxBits-1:0]   free_idx, hit_idx;
  logic                 free_found;

  assign exp_d = exp_q + {16'd0, mss_q};

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    hit_idx    = '0;
    for (int i = HoldDepth - 1; i >= 0; i--) begin
      dup_v[i] = hv_q[i] && (hseq_q[i] == seq_q);
      hit_v[i] = hv_q[i] && (hseq_q[i] == exp_q);
      if (!hv_q[i]) begin
        free_idx   = IdxBits'(i);
        free_found = 1'b1;
      end
      if (hit_v[i]) hit_idx = IdxBits'(i);
    end
  end

  always_comb begin
    sts_o.valid_tcp    = valid_q;
    sts_o.stale_or_dup = (seq_q < exp_q) || (|dup_v);
    sts_o.is_expected  = seq_q == exp_q;
    sts_o.emits        = emits_q;
    sts_o.hit          = |hit_v;
    sts_o.hit_emits    = hemit_q[hit_idx];
    sts_o.full         = !free_found;
  end

  assign mss_o      = mss_q;
  assign item_tag_o = tag_q;
  assign emit_tag_o = cmd_i.sel_held ? htag_q[hit_idx] : etag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seq_q   <= in_seq_i;
      tag_q   <= in_tag_i;
      etag_q  <= in_frag_i ? in_orig_i : in_tag_i;
      emits_q <= !in_frag_i || in_lastf_i;
    end
    if (cmd_i.hold) begin
      hseq_q[free_idx]  <= seq_q;
      htag_q[free_idx]  <= etag_q;
      hemit_q[free_idx] <= emits_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      exp_q   <= SeqReset;
      mss_q   <= MssReset;
      hv_q    <= '0;
    end else begin
      if (cmd_i.load) valid_q <= in_valid_tcp_i;
      if (cfg_we_i) mss_q <= cfg_data_i;
      if (cmd_i.hold) hv_q[free_idx] <= 1'b1;
      if (cmd_i.take_hit) hv_q[hit_idx] <= 1'b0;
      if (cmd_i.advance) begin
        exp_q <= exp_d;
        for (int i = 0; i < HoldDepth; i++) begin
          if (hseq_q[i] < exp_d) hv_q[i] <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/trb_ctrl.sv
// ----------------------------------------------------------------------------
// trb_ctrl: sequencing controller of the reorder buffer
// Steps through classify, ordered emission, drain and copy for one packet.
// ----------------------------------------------------------------------------
module trb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    out_port_o,
  output logic          out_ovf_o,
  output logic          out_last_o,
  output logic          out_sel_item_o,
  output trb_pkg::cmd_t cmd_o,
  input  trb_pkg::sts_t sts_i
);
  import trb_pkg::*;

  state_e state_q, state_d;
  logic   ovf_q, ovf_d;
  logic   held_q, held_d;  // the beat being emitted comes from the table
  logic   acc;

  assign acc = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    held_d  = held_q;
    case (state_q)
      StIdle:     if (in_valid_i) state_d = StClassify;
      StClassify: begin
        ovf_d  = 1'b0;
        held_d = 1'b0;
        if (!sts_i.valid_tcp || sts_i.stale_or_dup) state_d = StCopy;
        else if (sts_i.is_expected) state_d = sts_i.emits ? StEmit : StAdvance;
        else begin
          ovf_d   = sts_i.full;
          state_d = StCopy;
        end
      end
      // The accepted emit beat has already advanced the expected number.
      StEmit:     if (acc) state_d = StScan;
      StAdvance:  state_d = StScan;
      StScan: begin
        if (!sts_i.hit) state_d = StCopy;
        else begin
          held_d  = 1'b1;
          state_d = sts_i.hit_emits ? StEmit : StAdvance;
        end
      end
      StCopy:     if (acc) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = state_q == StIdle;
    out_valid_o    = (state_q == StEmit) || (state_q == StCopy);
    out_port_o     = PortOrdered;
    out_ovf_o      = 1'b0;
    out_last_o     = 1'b0;
    out_sel_item_o = 1'b0;
    case (state_q)
      StIdle:     cmd_o.load = in_valid_i;
      StClassify: cmd_o.hold = sts_i.valid_tcp && !sts_i.stale_or_dup &&
                               !sts_i.is_expected && !sts_i.full;
      StEmit: begin
        cmd_o.sel_held = held_q;
        // Leaving the emit state advances the expected number directly
        // and, for a drained entry, frees it together with the advance.
        cmd_o.advance  = acc;
        cmd_o.take_hit = acc && held_q;
      end
      StAdvance:  cmd_o.advance = 1'b1;
      StScan:     cmd_o.take_hit = sts_i.hit && !sts_i.hit_emits;
      StCopy: begin
        out_port_o     = sts_i.valid_tcp ? PortAllTcp : PortNonTcp;
        out_ovf_o      = ovf_q;
        out_last_o     = 1'b1;
        out_sel_item_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovf_q   <= 1'b0;
      held_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> src/tcp_reorder_buffer_top.sv
// ----------------------------------------------------------------------------
// tcp_reorder_buffer_top: TCP receive reorder buffer
// Sorts TCP packet descriptors by sequence number through a 16-entry table.
// ----------------------------------------------------------------------------
// One descriptor is taken at a time. A non-TCP descriptor passes through
// capture, classify and one copy beat. A valid TCP descriptor takes the
// same steps when stale, duplicate or out of order, and an in-order one
// adds an emit or advance step and a scan, repeated for each held entry
// drained behind it, since each drain step of the controller compares the
// expected number against all held entries and then advances it by the MSS.
// Output backpressure can stall each beat. The result beats of one
// descriptor are the ordered-port beats first, then one copy beat with tlast.
module tcp_reorder_buffer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: seq_number[31:0], item_tag[47:32], original_tag[63:48]
  input  logic [63:0] s_axis_tdata,
  // tuser: is_valid_tcp[0], is_fragment[1], is_last_fragment[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_tag[15:0], store_overflow[16], zero fill above
  output logic [23:0] m_axis_tdata,
  // tuser: out_port[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import trb_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [15:0]        mss;
  logic [TagBits-1:0] item_tag, emit_tag;
  logic               sel_item, ovf, cfg_we;

  assign pready = 1'b1;
  // The only register, mss, sits at byte address zero.
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegMss);
  assign prdata = (paddr[2] == RegMss) ? {16'd0, mss} : 32'd0;

  trb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_port_o     (m_axis_tuser),
    .out_ovf_o      (ovf),
    .out_last_o     (m_axis_tlast),
    .out_sel_item_o (sel_item),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  trb_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_tcp_i (s_axis_tuser[0]),
    .in_seq_i       (s_axis_tdata[31:0]),
    .in_tag_i       (s_axis_tdata[47:32]),
    .in_frag_i      (s_axis_tuser[1]),
    .in_lastf_i     (s_axis_tuser[2]),
    .in_orig_i      (s_axis_tdata[63:48]),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (pwdata[15:0]),
    .mss_o          (mss),
    .item_tag_o     (item_tag),
    .emit_tag_o     (emit_tag)
  );

  assign m_axis_tdata = {7'd0, ovf, sel_item ? item_tag : emit_tag};

endmodule
